FILE: src/gbfr_pkg.sv
// ----------------------------------------------------------------------------
// gbfr_pkg
// Shared types and constants of the binary frame receiver: result codes,
// configuration register indexes and the item format of the front queue.
// ----------------------------------------------------------------------------
package gbfr_pkg;

	// result codes carried on event_kind
	typedef enum logic [1:0] {
		EV_GOOD     = 2'd0,
		EV_CSUM_BAD = 2'd1,
		EV_OVERSIZE = 2'd2,
		EV_READ     = 2'd3
	} event_kind_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

	// configuration reset values
	localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

	// fixed field widths
	localparam int unsigned READ_IDX_W = 7;
	localparam int unsigned READ_SPAN  = 128;

	// classified item handed from front to back
	typedef struct packed {
		logic                  is_read;
		logic [7:0]            data_byte;
		logic [READ_IDX_W-1:0] read_index;
		logic                  hit_first;
		logic                  hit_second;
	} item_t;

endpackage

FILE: src/gbfr_front.sv
// ----------------------------------------------------------------------------
// gbfr_front
// Input side: holds the preamble registers, accepts items and tags each
// serial byte with its preamble matches before it enters the queue.
// ----------------------------------------------------------------------------
module gbfr_front (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_valid,
	input  logic [gbfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [7:0]                         data_byte,
	input  logic [gbfr_pkg::READ_IDX_W-1:0]    read_index,
	// queue side
	input  logic                               q_full,
	output logic                               q_push,
	output gbfr_pkg::item_t                    q_item
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;

	// preamble registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= gbfr_pkg::SYNC_FIRST_RST;
			sync_second_q <= gbfr_pkg::SYNC_SECOND_RST;
		end else if (cfg_valid) begin
			if (cfg_index == gbfr_pkg::CFG_SYNC_FIRST) begin
				sync_first_q <= cfg_data;
			end
			if (cfg_index == gbfr_pkg::CFG_SYNC_SECOND) begin
				sync_second_q <= cfg_data;
			end
		end
	end

	// accept while the queue has room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// classify the item
	always_comb begin
		q_item            = '0;
		q_item.is_read    = mode;
		q_item.data_byte  = data_byte;
		q_item.read_index = read_index;
		q_item.hit_first  = (data_byte == sync_first_q);
		q_item.hit_second = (data_byte == sync_second_q);
	end

endmodule

FILE: src/gbfr_queue.sv
// ----------------------------------------------------------------------------
// gbfr_queue
// Two-entry item queue between the front and the parser, so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module gbfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gbfr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output gbfr_pkg::item_t head_item
);

	gbfr_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_item = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: src/gbfr_back.sv
// ----------------------------------------------------------------------------
// gbfr_back
// Parser side: frame state machine, Fletcher checksum, payload store and
// the result register that drives the output channel.
// ----------------------------------------------------------------------------
module gbfr_back #(
	parameter int unsigned MAX_PAYLOAD = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	// queue side
	input  logic            q_not_empty,
	input  gbfr_pkg::item_t q_item,
	output logic            q_pop,
	// output channel
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      event_kind,
	output logic [7:0]      frame_class,
	output logic [7:0]      frame_id,
	output logic [15:0]     frame_length,
	output logic [7:0]      read_data
);

	// only the first positions are reachable by a read
	localparam int unsigned STORE_DEPTH =
		(MAX_PAYLOAD < gbfr_pkg::READ_SPAN) ? MAX_PAYLOAD : gbfr_pkg::READ_SPAN;
	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_CLASS,
		ST_ID,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CK_A,
		ST_CK_B
	} step_t;

	step_t                 step_q,  step_d;
	logic [7:0]            class_q, class_d;
	logic [7:0]            id_q,    id_d;
	logic [15:0]           len_q,   len_d;
	logic [CNT_W-1:0]      cnt_q,   cnt_d;
	logic [7:0]            sum_a_q, sum_a_d;
	logic [7:0]            sum_b_q, sum_b_d;
	logic [STORE_DEPTH-1:0] stored_q;

	logic                  out_valid_q;
	gbfr_pkg::event_kind_t kind_q;
	logic [7:0]            out_class_q;
	logic [7:0]            out_id_q;
	logic [15:0]           out_len_q;
	logic                  rd_hit_q;
	logic [7:0]            rdata_q;

	logic [7:0]            store_mem [STORE_DEPTH];

	logic                  emit;
	gbfr_pkg::event_kind_t emit_kind;
	logic [7:0]            b;
	logic [7:0]            acc_a;
	logic [7:0]            acc_b;
	logic [15:0]           full_len;
	logic [CNT_W-1:0]      cnt_inc;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  rd_in_range;

	// advance when the result register is free or being drained
	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);

	assign b        = q_item.data_byte;
	assign acc_a    = sum_a_q + b;
	assign acc_b    = sum_b_q + acc_a;
	assign full_len = {b, len_q[7:0]};
	assign cnt_inc  = cnt_q + CNT_W'(1);

	// store addressing
	assign wr_addr     = cnt_q[ADDR_W-1:0];
	assign rd_addr     = q_item.read_index[ADDR_W-1:0];
	assign rd_in_range = ({1'b0, q_item.read_index} < 8'(STORE_DEPTH));
	assign wr_en       = q_pop && !q_item.is_read && (step_q == ST_PAYLOAD)
		&& (cnt_q < CNT_W'(STORE_DEPTH));

	// frame parser next state
	always_comb begin
		step_d    = step_q;
		class_d   = class_q;
		id_d      = id_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		emit      = 1'b0;
		emit_kind = gbfr_pkg::EV_READ;
		if (q_pop) begin
			if (q_item.is_read) begin
				emit = 1'b1;
			end else begin
				unique case (step_q)
					ST_SYNC2: begin
						if (q_item.hit_second) begin
							step_d = ST_CLASS;
						end else if (q_item.hit_first) begin
							step_d = ST_SYNC2;
						end else begin
							step_d = ST_HUNT;
						end
					end
					ST_CLASS: begin
						class_d = b;
						sum_a_d = b;
						sum_b_d = b;
						step_d  = ST_ID;
					end
					ST_ID: begin
						id_d    = b;
						sum_a_d = acc_a;
						sum_b_d = acc_b;
						step_d  = ST_LEN_LO;
					end
					ST_LEN_LO: begin
						len_d   = {8'd0, b};
						sum_a_d = acc_a;
						sum_b_d = acc_b;
						step_d  = ST_LEN_HI;
					end
					ST_LEN_HI: begin
						len_d   = full_len;
						sum_a_d = acc_a;
						sum_b_d = acc_b;
						cnt_d   = '0;
						if (full_len > 16'(MAX_PAYLOAD)) begin
							step_d    = ST_HUNT;
							emit      = 1'b1;
							emit_kind = gbfr_pkg::EV_OVERSIZE;
						end else if (full_len == 16'd0) begin
							step_d = ST_CK_A;
						end else begin
							step_d = ST_PAYLOAD;
						end
					end
					ST_PAYLOAD: begin
						sum_a_d = acc_a;
						sum_b_d = acc_b;
						cnt_d   = cnt_inc;
						if (16'(cnt_inc) >= len_q) begin
							step_d = ST_CK_A;
						end
					end
					ST_CK_A: begin
						if (b != sum_a_q) begin
							step_d    = ST_HUNT;
							emit      = 1'b1;
							emit_kind = gbfr_pkg::EV_CSUM_BAD;
						end else begin
							step_d = ST_CK_B;
						end
					end
					ST_CK_B: begin
						step_d    = ST_HUNT;
						emit      = 1'b1;
						emit_kind = (b == sum_b_q) ? gbfr_pkg::EV_GOOD
							: gbfr_pkg::EV_CSUM_BAD;
					end
					default: begin
						step_d = q_item.hit_first ? ST_SYNC2 : ST_HUNT;
					end
				endcase
			end
		end
	end

	// parser state, written marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_HUNT;
			class_q     <= '0;
			id_q        <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			stored_q    <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= gbfr_pkg::EV_GOOD;
			out_class_q <= '0;
			out_id_q    <= '0;
			out_len_q   <= '0;
			rd_hit_q    <= 1'b0;
		end else begin
			step_q  <= step_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			if (wr_en) begin
				stored_q[wr_addr] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				kind_q      <= emit_kind;
				if (q_item.is_read) begin
					out_class_q <= '0;
					out_id_q    <= '0;
					out_len_q   <= '0;
					rd_hit_q    <= rd_in_range && stored_q[rd_addr];
				end else begin
					out_class_q <= class_q;
					out_id_q    <= id_q;
					out_len_q   <= len_d;
					rd_hit_q    <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= b;
		end
		if (q_pop && q_item.is_read) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign frame_class  = out_class_q;
	assign frame_id     = out_id_q;
	assign frame_length = out_len_q;
	assign read_data    = rd_hit_q ? rdata_q : 8'd0;

endmodule

FILE: src/gnss_binary_frame_receiver.sv
// Each accepted item passes the queue, then its result is registered as valid.
// Throughput: one byte or read item per cycle while the output is not stalled.
// A two-entry queue lets input keep flowing while a result waits to be taken.
// Reset sets the parser and the preamble registers to their start values and
// clears the written marks of the payload store, so unwritten positions read as zero.
// ----------------------------------------------------------------------------
// gnss_binary_frame_receiver
// Serial frame receiver with preamble hunt, length check, payload store and
// 8-bit Fletcher checksum; also serves reads of the stored payload.
// ----------------------------------------------------------------------------
module gnss_binary_frame_receiver #(
	parameter int unsigned MAX_PAYLOAD = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [7:0]                      data_byte,
	input  logic [gbfr_pkg::READ_IDX_W-1:0] read_index,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      event_kind,
	output logic [7:0]                      frame_class,
	output logic [7:0]                      frame_id,
	output logic [15:0]                     frame_length,
	output logic [7:0]                      read_data
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_not_empty;
	gbfr_pkg::item_t push_item;
	gbfr_pkg::item_t head_item;

	assign cfg_ready = 1'b1;

	// accept and classify
	gbfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data_byte  (data_byte),
		.read_index (read_index),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	// decoupling queue
	gbfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	// parser, store and result register
	gbfr_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_item       (head_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.frame_class  (frame_class),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.read_data    (read_data)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes and store reads into the frame receiver and checks every
// verdict and read item against a cycle-free model of the parser, over several
// preamble settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STORE_DEPTH  = 128;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 150;

	typedef logic [gbfr_pkg::CFG_IDX_W-1:0]  cidx_t;
	typedef logic [gbfr_pkg::READ_IDX_W-1:0] ridx_t;

	// spare register indexes, writes to them must be ignored
	localparam cidx_t CFG_IDX_SPARE_A = 2'd2;
	localparam cidx_t CFG_IDX_SPARE_B = 2'd3;

	typedef enum logic [3:0] {
		P_HUNT, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_BODY, P_CK_A, P_CK_B
	} parse_step_t;

	// ways a generated frame can be damaged
	typedef enum int {FLAW_NONE, FLAW_CK_A, FLAW_CK_B, FLAW_CUT} flaw_t;

	typedef struct {
		gbfr_pkg::event_kind_t kind;
		logic [7:0]            cls;
		logic [7:0]            id;
		logic [15:0]           len;
		logic [7:0]            rd;
	} verdict_t;

	// frame parser model and queue of pending verdicts
	class frame_scoreboard;
		logic [7:0]  sync_a;
		logic [7:0]  sync_b;
		parse_step_t step;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
		logic [15:0] cnt;
		logic [7:0]  ck_a;
		logic [7:0]  ck_b;
		logic [7:0]  store [STORE_DEPTH];
		verdict_t    due [$];
		int          errors;

		function new();
			sync_a = gbfr_pkg::SYNC_FIRST_RST;
			sync_b = gbfr_pkg::SYNC_SECOND_RST;
			step   = P_HUNT;
			cls    = 8'd0;
			id     = 8'd0;
			len    = 16'd0;
			cnt    = 16'd0;
			ck_a   = 8'd0;
			ck_b   = 8'd0;
			errors = 0;
			foreach (store[i]) store[i] = 8'd0;
		endfunction

		function void write_reg(cidx_t idx, logic [7:0] val);
			case (idx)
				gbfr_pkg::CFG_SYNC_FIRST: sync_a = val;
				gbfr_pkg::CFG_SYNC_SECOND: sync_b = val;
				default: ;
			endcase
		endfunction

		// advance the parser by one accepted item
		function void note_item(logic m, logic [7:0] b, ridx_t ri);
			verdict_t v;
			bit       hit;
			hit = 1'b0;
			v = '{gbfr_pkg::EV_READ, 8'd0, 8'd0, 16'd0, 8'd0};
			if (m) begin
				v.rd = (ri < STORE_DEPTH) ? store[ri] : 8'd0;
				hit = 1'b1;
			end else begin
				case (step)
					// a wrong second byte may itself be a first sync
					P_SYNC2: begin
						if (b == sync_b)
							step = P_CLASS;
						else
							step = (b == sync_a) ? P_SYNC2 : P_HUNT;
					end
					P_CLASS: begin
						cls  = b;
						ck_a = b;
						ck_b = b;
						step = P_ID;
					end
					P_ID: begin
						id   = b;
						ck_a = ck_a + b;
						ck_b = ck_b + ck_a;
						step = P_LEN_LO;
					end
					P_LEN_LO: begin
						len  = {8'd0, b};
						ck_a = ck_a + b;
						ck_b = ck_b + ck_a;
						step = P_LEN_HI;
					end
					// oversize drops the frame, zero length skips the body
					P_LEN_HI: begin
						ck_a = ck_a + b;
						ck_b = ck_b + ck_a;
						len[15:8] = b;
						cnt = 16'd0;
						if (len > STORE_DEPTH) begin
							step = P_HUNT;
							v.kind = gbfr_pkg::EV_OVERSIZE;
							hit = 1'b1;
						end else begin
							step = (len == 16'd0) ? P_CK_A : P_BODY;
						end
					end
					P_BODY: begin
						ck_a = ck_a + b;
						ck_b = ck_b + ck_a;
						if (cnt < STORE_DEPTH)
							store[cnt[6:0]] = b;
						cnt = cnt + 16'd1;
						if (cnt >= len)
							step = P_CK_A;
					end
					// first checksum byte wrong ends the frame at once
					P_CK_A: begin
						if (b != ck_a) begin
							step = P_HUNT;
							v.kind = gbfr_pkg::EV_CSUM_BAD;
							hit = 1'b1;
						end else begin
							step = P_CK_B;
						end
					end
					P_CK_B: begin
						step = P_HUNT;
						v.kind = (b == ck_b) ? gbfr_pkg::EV_GOOD : gbfr_pkg::EV_CSUM_BAD;
						hit = 1'b1;
					end
					default: step = (b == sync_a) ? P_SYNC2 : P_HUNT;
				endcase
				if (hit) begin
					v.cls = cls;
					v.id  = id;
					v.len = len;
				end
			end
			if (hit)
				due.push_back(v);
		endfunction

		// compare one result item with the oldest pending verdict
		function void check_result(logic [1:0] kind, logic [7:0] c, logic [7:0] i,
				logic [15:0] l, logic [7:0] rd);
			verdict_t v;
			if (due.size() == 0) begin
				$error("result with nothing pending: event_kind %0d", kind);
				errors++;
				return;
			end
			v = due.pop_front();
			if (kind !== v.kind) begin
				$error("event_kind: expected %0d, actual %0d", v.kind, kind);
				errors++;
			end
			if (c !== v.cls) begin
				$error("frame_class: expected %0d, actual %0d", v.cls, c);
				errors++;
			end
			if (i !== v.id) begin
				$error("frame_id: expected %0d, actual %0d", v.id, i);
				errors++;
			end
			if (l !== v.len) begin
				$error("frame_length: expected %0d, actual %0d", v.len, l);
				errors++;
			end
			if (rd !== v.rd) begin
				$error("read_data: expected %0d, actual %0d", v.rd, rd);
				errors++;
			end
		endfunction
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	cidx_t       cfg_index  = gbfr_pkg::CFG_SYNC_FIRST;
	logic [7:0]  cfg_data   = 8'd0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        mode       = 1'b0;
	logic [7:0]  data_byte  = 8'd0;
	ridx_t       read_index = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [15:0] frame_length;
	logic [7:0]  read_data;

	frame_scoreboard sb;
	int              idle_pct   = 0;
	int              stall_pct  = 0;
	int              hold_left  = 0;
	int              items_sent = 0;
	logic [7:0]      sync1_now  = gbfr_pkg::SYNC_FIRST_RST;
	logic [7:0]      sync2_now  = gbfr_pkg::SYNC_SECOND_RST;

	gnss_binary_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.data_byte    (data_byte),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.frame_class  (frame_class),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.read_data    (read_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check accepted items, then pick next stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(event_kind, frame_class, frame_id, frame_length, read_data);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// offer one item after a random gap and wait until it is taken
	task automatic send_item(logic m, logic [7:0] b, ridx_t ri);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		data_byte  <= b;
		read_index <= ri;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(m, b, ri);
		items_sent++;
	endtask

	// store read, biased toward the low positions that short frames fill
	task automatic send_read();
		ridx_t ri;
		ri = $urandom_range(1) ? ridx_t'($urandom_range(15)) : ridx_t'($urandom_range(127));
		send_item(1'b1, 8'($urandom), ri);
	endtask

	// serial byte, sometimes preceded by a store read
	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(99) < 10)
			send_read();
		send_item(1'b0, b, ridx_t'($urandom));
	endtask

	// build a frame with the current preamble and send it byte by byte
	task automatic send_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
			flaw_t flaw);
		logic [7:0] q [$];
		logic [7:0] a;
		logic [7:0] s;
		q = '{sync1_now, sync2_now, cls, id, len[7:0], len[15:8]};
		a = 8'd0;
		s = 8'd0;
		for (int i = 2; i < 6; i++) begin
			a = a + q[i];
			s = s + a;
		end
		if (len <= STORE_DEPTH) begin
			for (int i = 0; i < len; i++) begin
				q.push_back(8'($urandom));
				a = a + q[q.size() - 1];
				s = s + a;
			end
			q.push_back((flaw == FLAW_CK_A) ? a ^ 8'($urandom_range(1, 255)) : a);
			q.push_back((flaw == FLAW_CK_B) ? s ^ 8'($urandom_range(1, 255)) : s);
		end
		// a cut frame lets the next bytes run into it
		if (flaw == FLAW_CUT)
			q = q[0:$urandom_range(0, q.size() - 2)];
		foreach (q[i])
			send_byte(q[i]);
	endtask

	// mostly well-formed frames, some damaged ones, noise and read bursts
	task automatic run_random(int n);
		int          start;
		int          r;
		int          f;
		logic [15:0] len;
		flaw_t       flaw;
		start = items_sent;
		while (items_sent - start < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				f = $urandom_range(99);
				if (f < 8)
					len = 16'd0;
				else if (f < 70)
					len = 16'($urandom_range(1, 12));
				else if (f < 82)
					len = 16'($urandom_range(13, 127));
				else if (f < 87)
					len = 16'(STORE_DEPTH);
				else if (f < 91)
					len = 16'(STORE_DEPTH + 1);
				else if (f < 97)
					len = 16'($urandom_range(130, 65534));
				else
					len = 16'hFFFF;
				f = $urandom_range(99);
				flaw = (f < 65) ? FLAW_NONE : (f < 78) ? FLAW_CK_A :
					(f < 90) ? FLAW_CK_B : FLAW_CUT;
				send_frame(8'($urandom), 8'($urandom), len, flaw);
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					send_read();
			end
		end
		in_valid <= 1'b0;
	endtask

	// wait until every pending verdict has come, then let the pipe drain
	task automatic settle();
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// one register write, valid left high for the caller to drop
	task automatic write_reg(cidx_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		if (idx == gbfr_pkg::CFG_SYNC_FIRST)
			sync1_now = val;
		else if (idx == gbfr_pkg::CFG_SYNC_SECOND)
			sync2_now = val;
	endtask

	// new preamble, with writes to the spare indexes around it
	task automatic set_sync(logic [7:0] first, logic [7:0] second);
		write_reg(CFG_IDX_SPARE_A, 8'($urandom));
		write_reg(gbfr_pkg::CFG_SYNC_FIRST, first);
		write_reg(gbfr_pkg::CFG_SYNC_SECOND, second);
		write_reg(CFG_IDX_SPARE_B, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// run limit
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// main sequence
	initial begin
		sb = new();
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: reads of the cleared store at both ends
		send_item(1'b1, 8'hFF, 7'd0);
		send_item(1'b1, 8'h00, 7'd127);
		// repeated first sync, then a zero-length good frame
		send_byte(gbfr_pkg::SYNC_FIRST_RST);
		send_frame(8'hFF, 8'h00, 16'd0, FLAW_NONE);
		// largest declared length, dropped as oversize
		send_frame(8'h00, 8'hFF, 16'hFFFF, FLAW_NONE);
		// first checksum byte wrong
		send_frame(8'h5A, 8'hA5, 16'd0, FLAW_CK_A);
		in_valid <= 1'b0;
		settle();

		// no idling, extreme preamble values
		set_sync(8'h00, 8'hFF);
		run_random(230);
		settle();

		// sender idles
		set_sync(8'hFF, 8'h00);
		idle_pct = 75;
		run_random(230);
		settle();

		// receiver stalls, both preamble bytes alike
		set_sync(8'h55, 8'h55);
		idle_pct = 0;
		stall_pct = 75;
		run_random(230);
		settle();

		// long receiver hold-off while the sender keeps offering
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (30)
			send_read();
		run_random(30);
		settle();

		// both sides idle, random preamble
		set_sync(8'($urandom), 8'($urandom));
		idle_pct = 20;
		stall_pct = 20;
		run_random(230);
		settle();

		// back to the reset preamble, no idling
		set_sync(gbfr_pkg::SYNC_FIRST_RST, gbfr_pkg::SYNC_SECOND_RST);
		idle_pct = 0;
		stall_pct = 0;
		run_random(230);
		settle();

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
